// ===== hw/rtl/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types, codes and timing helpers of the one-wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

    // Command codes carried in the mode field
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_RESET_LOW      = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT  = 3'd1;
    localparam logic [2:0] REG_RESET_TAIL     = 3'd2;
    localparam logic [2:0] REG_SLOT_LOW       = 3'd3;
    localparam logic [2:0] REG_WRITE_HOLD     = 3'd4;
    localparam logic [2:0] REG_WRITE_RECOVERY = 3'd5;
    localparam logic [2:0] REG_READ_SAMPLE    = 3'd6;
    localparam logic [2:0] REG_READ_TAIL      = 3'd7;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned TIME_W = 10;

    // Register reset values
    localparam logic [9:0] RST_RESET_LOW      = 10'd480;
    localparam logic [9:0] RST_PRESENCE_WAIT  = 10'd100;
    localparam logic [9:0] RST_RESET_TAIL     = 10'd380;
    localparam logic [5:0] RST_SLOT_LOW       = 6'd2;
    localparam logic [6:0] RST_WRITE_HOLD     = 7'd58;
    localparam logic [5:0] RST_WRITE_RECOVERY = 6'd1;
    localparam logic [5:0] RST_READ_SAMPLE    = 6'd10;
    localparam logic [6:0] RST_READ_TAIL      = 7'd49;

    typedef enum logic [3:0] {
        OP_IDLE  = 4'b0001,
        OP_RESET = 4'b0010,
        OP_WRITE = 4'b0100,
        OP_READ  = 4'b1000
    } t_op;

    // Low pulse, middle part (reset release / write hold / read sample), tail
    typedef enum logic [2:0] {
        PH_LOW  = 3'b001,
        PH_MID  = 3'b010,
        PH_TAIL = 3'b100
    } t_phase;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [9:0] presence_wait_us;
        logic [9:0] reset_tail_us;
        logic [5:0] slot_low_us;
        logic [6:0] write_hold_us;
        logic [5:0] write_recovery_us;
        logic [5:0] read_sample_us;
        logic [6:0] read_tail_us;
    } t_cfg;

    function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
        return (v == '0) ? TIME_W'(1) : v;
    endfunction

    function automatic t_op mode_to_op(input logic [1:0] mode);
        t_op op;
        case (mode)
            MODE_RESET: op = OP_RESET;
            MODE_WRITE: op = OP_WRITE;
            MODE_READ:  op = OP_READ;
            default:    op = OP_IDLE;
        endcase
        return op;
    endfunction

    // Tick count of one phase of the given operation
    function automatic logic [TIME_W-1:0] phase_len(input t_op op, input t_phase ph,
                                                    input t_cfg c);
        logic [TIME_W-1:0] len;
        len = '0;
        case (op)
            OP_RESET: begin
                case (ph)
                    PH_LOW:  len = at_least_one(c.reset_low_us);
                    PH_MID:  len = at_least_one(c.presence_wait_us);
                    default: len = c.reset_tail_us;
                endcase
            end
            OP_WRITE: begin
                case (ph)
                    PH_LOW:  len = at_least_one(TIME_W'(c.slot_low_us));
                    PH_MID:  len = at_least_one(TIME_W'(c.write_hold_us));
                    default: len = TIME_W'(c.write_recovery_us);
                endcase
            end
            default: begin
                case (ph)
                    PH_LOW:  len = at_least_one(TIME_W'(c.slot_low_us));
                    PH_MID:  len = at_least_one(TIME_W'(c.read_sample_us));
                    default: len = TIME_W'(c.read_tail_us);
                endcase
            end
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/owm_regs.sv =====
// ----------------------------------------------------------------------------
// owm_regs
// APB timing register file of the one-wire bus master.
// ----------------------------------------------------------------------------
module owm_regs import owm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_us      <= RST_RESET_LOW;
            r_cfg.presence_wait_us  <= RST_PRESENCE_WAIT;
            r_cfg.reset_tail_us     <= RST_RESET_TAIL;
            r_cfg.slot_low_us       <= RST_SLOT_LOW;
            r_cfg.write_hold_us     <= RST_WRITE_HOLD;
            r_cfg.write_recovery_us <= RST_WRITE_RECOVERY;
            r_cfg.read_sample_us    <= RST_READ_SAMPLE;
            r_cfg.read_tail_us      <= RST_READ_TAIL;
        end else if (wr_en) begin
            case (idx)
                REG_RESET_LOW:      r_cfg.reset_low_us      <= pwdata[9:0];
                REG_PRESENCE_WAIT:  r_cfg.presence_wait_us  <= pwdata[9:0];
                REG_RESET_TAIL:     r_cfg.reset_tail_us     <= pwdata[9:0];
                REG_SLOT_LOW:       r_cfg.slot_low_us       <= pwdata[5:0];
                REG_WRITE_HOLD:     r_cfg.write_hold_us     <= pwdata[6:0];
                REG_WRITE_RECOVERY: r_cfg.write_recovery_us <= pwdata[5:0];
                REG_READ_SAMPLE:    r_cfg.read_sample_us    <= pwdata[5:0];
                REG_READ_TAIL:      r_cfg.read_tail_us      <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_RESET_LOW:      prdata = DATA_W'(r_cfg.reset_low_us);
            REG_PRESENCE_WAIT:  prdata = DATA_W'(r_cfg.presence_wait_us);
            REG_RESET_TAIL:     prdata = DATA_W'(r_cfg.reset_tail_us);
            REG_SLOT_LOW:       prdata = DATA_W'(r_cfg.slot_low_us);
            REG_WRITE_HOLD:     prdata = DATA_W'(r_cfg.write_hold_us);
            REG_WRITE_RECOVERY: prdata = DATA_W'(r_cfg.write_recovery_us);
            REG_READ_SAMPLE:    prdata = DATA_W'(r_cfg.read_sample_us);
            REG_READ_TAIL:      prdata = DATA_W'(r_cfg.read_tail_us);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/owm_core.sv =====
// ----------------------------------------------------------------------------
// owm_core
// Bus sequencer: advances operation, phase, timer, bit and shift state by one tick.
// ----------------------------------------------------------------------------
module owm_core import owm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_tx_byte,
    input  logic       i_line_in,
    input  t_cfg       i_cfg,
    output logic       o_drive_low,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_no_device,
    output logic [7:0] o_rx_byte
);

    t_op               r_op,    n_op,    op_c;
    t_phase            r_phase, n_phase, ph_c;
    logic [TIME_W-1:0] r_tl,    n_tl,    tl_c, tl_dec, tail_len;
    logic [2:0]        r_bit,   n_bit,   bit_c;
    logic [7:0]        r_shift, n_shift, sh_c;
    logic              r_presence, n_presence;
    logic [7:0]        r_rx,    n_rx;
    logic              slot_end, finish;

    always_comb begin
        op_c  = r_op;
        ph_c  = r_phase;
        tl_c  = r_tl;
        bit_c = r_bit;
        sh_c  = r_shift;
        // A command is only taken while idle
        if (r_op == OP_IDLE && i_mode != MODE_TICK) begin
            op_c  = mode_to_op(i_mode);
            ph_c  = PH_LOW;
            bit_c = '0;
            sh_c  = (i_mode == MODE_WRITE) ? i_tx_byte : 8'h00;
            tl_c  = phase_len(op_c, PH_LOW, i_cfg);
        end

        n_op        = op_c;
        n_phase     = ph_c;
        n_tl        = tl_c;
        n_bit       = bit_c;
        n_shift     = sh_c;
        n_presence  = r_presence;
        n_rx        = r_rx;
        o_drive_low = 1'b0;
        o_busy_res  = 1'b0;
        o_done_res  = 1'b0;
        slot_end    = 1'b0;
        finish      = 1'b0;
        tl_dec      = tl_c - TIME_W'(1);
        tail_len    = phase_len(op_c, PH_TAIL, i_cfg);

        if (op_c != OP_IDLE) begin
            o_busy_res  = 1'b1;
            o_drive_low = (ph_c == PH_LOW) ||
                          (op_c == OP_WRITE && ph_c == PH_MID && !sh_c[0]);
            n_tl = tl_dec;
            if (tl_dec == '0) begin
                if (ph_c == PH_MID && op_c == OP_RESET) begin
                    n_presence = i_line_in;
                end
                if (ph_c == PH_MID && op_c == OP_READ) begin
                    n_shift = {i_line_in, sh_c[7:1]};
                end
                case (ph_c)
                    PH_LOW: begin
                        n_phase = PH_MID;
                        n_tl    = phase_len(op_c, PH_MID, i_cfg);
                    end
                    PH_MID: begin
                        n_phase  = PH_TAIL;
                        n_tl     = tail_len;
                        slot_end = (tail_len == '0);
                    end
                    default: slot_end = 1'b1;
                endcase
                if (slot_end) begin
                    if (op_c == OP_RESET) begin
                        finish = 1'b1;
                    end else begin
                        if (op_c == OP_WRITE) begin
                            n_shift = {1'b0, n_shift[7:1]};
                        end
                        if (bit_c == 3'd7) begin
                            finish = 1'b1;
                        end else begin
                            n_bit   = bit_c + 3'd1;
                            n_phase = PH_LOW;
                            n_tl    = phase_len(op_c, PH_LOW, i_cfg);
                        end
                    end
                end
                if (finish) begin
                    if (op_c == OP_READ) begin
                        n_rx = n_shift;
                    end
                    n_op       = OP_IDLE;
                    n_phase    = PH_LOW;
                    n_tl       = '0;
                    n_bit      = '0;
                    o_done_res = 1'b1;
                end
            end
        end
    end

    assign o_no_device = n_presence;
    assign o_rx_byte   = n_rx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op       <= OP_IDLE;
            r_phase    <= PH_LOW;
            r_tl       <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_presence <= 1'b0;
            r_rx       <= '0;
        end else if (i_step) begin
            r_op       <= n_op;
            r_phase    <= n_phase;
            r_tl       <= n_tl;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_presence <= n_presence;
            r_rx       <= n_rx;
        end
    end

endmodule

// ===== hw/rtl/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master: reset/presence, write byte and read byte, one tick a beat.
// ----------------------------------------------------------------------------
// Output: an accepted tick beat gives its result beat in the next cycle.
// Throughput: one tick beat per cycle while o_stall is low; the sequencer state advances
//   once per accepted beat, so the one-tick state update sets the rate.
// Reset: synchronous, active low; operation goes idle, timers, counters, the
//   presence flag and the last read byte clear, timing registers reload defaults.
// ----------------------------------------------------------------------------
module one_wire_bus_master import owm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // tick channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_tx_byte,
    input  logic              i_line_in,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_drive_low,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic              o_no_device,
    output logic [7:0]        o_rx_byte,
    // timing registers
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg       cfg;
    logic       in_take;
    logic       c_drive, c_busy, c_done, c_no_dev;
    logic [7:0] c_rx;

    logic       r_valid;
    logic       r_drive, r_busy, r_done, r_no_dev;
    logic [7:0] r_rx;

    owm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Hold the input only while the result register is full and stalled;
    // a result leaving this cycle frees the slot for the next beat.
    assign o_stall = r_valid && i_stall;
    assign in_take = i_valid && !o_stall;

    // Sequencer state advances once per accepted tick
    owm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_take),
        .i_mode      (i_mode),
        .i_tx_byte   (i_tx_byte),
        .i_line_in   (i_line_in),
        .i_cfg       (cfg),
        .o_drive_low (c_drive),
        .o_busy_res  (c_busy),
        .o_done_res  (c_done),
        .o_no_device (c_no_dev),
        .o_rx_byte   (c_rx)
    );

    // Result register: load on every accepted tick, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_drive  <= c_drive;
            r_busy   <= c_busy;
            r_done   <= c_done;
            r_no_dev <= c_no_dev;
            r_rx     <= c_rx;
        end
    end

    assign o_valid     = r_valid;
    assign o_drive_low = r_drive;
    assign o_busy_res  = r_busy;
    assign o_done_res  = r_done;
    assign o_no_device = r_no_dev;
    assign o_rx_byte   = r_rx;

    // Every accepted tick produces a result beat on the next cycle
    a_take_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_valid)
        else $error("accepted tick did not produce a result beat");

    // The bus is only pulled low during an operation
    a_drive_in_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_drive_low) |-> o_busy_res)
        else $error("bus driven low while idle");

    // Completion is flagged only on a busy tick
    a_done_in_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> o_busy_res)
        else $error("done flagged outside an operation");

endmodule
